/* rtl/ljf_pkg.sv */
// Package for the longest-job-first scheduler.
// Holds field widths, operation codes and the queue entry types.
// Used by ljf_cell, ljf_chain and longest_job_first_scheduler.
`timescale 1ns / 1ps

package ljf_pkg;

    localparam int IDENT_W     = 8;
    localparam int LEN_W       = 16;
    localparam int TICK_W      = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int QUEUE_DEPTH = 16;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [IDENT_W-1:0] ident;
        logic [LEN_W-1:0]   length;
        logic [TICK_W-1:0]  arrival;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_cmd;

endpackage

/* rtl/longest_job_first_scheduler.sv */
// Top level of the non-preemptive longest-job-first scheduler.
// Instantiates ljf_chain; depends on ljf_pkg.
//
// Usage:
// The input channel (i_in_valid, o_in_stall) carries one transaction per
// event: an arrival (job identifier and length) or one clock tick. Each input
// transaction produces exactly one output transaction on (o_out_valid,
// i_out_stall) carrying acceptance, dispatch, finish and queue status.
// Arrivals are inserted into a row of cells kept sorted by length, so the job
// to dispatch always sits in the head cell and a tick retires, dispatches and
// pops in the same cycle.
// The result is registered at the edge after the input transaction. The
// block takes one transaction at a time, so a new input is taken only once
// the previous result has left. While the receiver stalls, the result holds
// and o_in_stall stays high.
// Reset clears the tick counter, the running job and all cell valid bits;
// the block is ready as soon as reset is released.
`timescale 1ns / 1ps

module longest_job_first_scheduler #(
    parameter int QUEUE_DEPTH = ljf_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_operation,
    input  logic [ljf_pkg::IDENT_W-1:0]       i_job_ident,
    input  logic [ljf_pkg::LEN_W-1:0]         i_job_length,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_accepted,
    output logic                              o_dispatch_valid,
    output logic [ljf_pkg::IDENT_W-1:0]       o_dispatch_ident,
    output logic [ljf_pkg::TICK_W-1:0]        o_dispatch_wait,
    output logic                              o_finish_valid,
    output logic [ljf_pkg::IDENT_W-1:0]       o_finish_ident,
    output logic                              o_server_busy,
    output logic [ljf_pkg::COUNT_OUT_W-1:0]   o_waiting_count
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                         r_out_valid;
    logic [ljf_pkg::TICK_W-1:0]   r_tick;
    logic                         r_run_flag;
    logic [ljf_pkg::IDENT_W-1:0]  r_run_ident;
    logic [ljf_pkg::LEN_W-1:0]    r_run_left;
    logic [CNT_W-1:0]             r_count;

    logic                         n_run_flag;
    logic [ljf_pkg::IDENT_W-1:0]  n_run_ident;
    logic [ljf_pkg::LEN_W-1:0]    n_run_left;
    logic [CNT_W-1:0]             n_count;

    logic                         r_accepted;
    logic                         r_dispatch_valid;
    logic [ljf_pkg::IDENT_W-1:0]  r_dispatch_ident;
    logic [ljf_pkg::TICK_W-1:0]   r_dispatch_wait;
    logic                         r_finish_valid;
    logic [ljf_pkg::IDENT_W-1:0]  r_finish_ident;

    logic                         w_take;
    logic                         w_tick;
    logic                         w_insert;
    logic                         w_finish;
    logic                         w_dispatch;
    logic                         w_full;
    ljf_pkg::t_entry              w_head;
    ljf_pkg::t_entry              w_new;
    ljf_pkg::t_cell_cmd           w_cmd;

    assign o_in_stall = r_out_valid;
    assign w_take     = i_in_valid && !r_out_valid;
    assign w_tick     = (i_operation == ljf_pkg::OP_TICK);

    assign w_insert   = w_take && !w_tick && !w_full && (i_job_length != '0);
    assign w_finish   = w_take && w_tick && r_run_flag && (r_run_left == '0);
    assign w_dispatch = w_take && w_tick && (!r_run_flag || w_finish) && w_head.valid;

    assign w_new.valid   = 1'b1;
    assign w_new.ident   = i_job_ident;
    assign w_new.length  = i_job_length;
    assign w_new.arrival = r_tick;

    assign w_cmd.insert = w_insert;
    assign w_cmd.pop    = w_dispatch;

    ljf_chain #(
        .DEPTH (QUEUE_DEPTH)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_new   (w_new),
        .o_head  (w_head),
        .o_full  (w_full)
    );

    always_comb begin
        n_run_flag  = r_run_flag;
        n_run_ident = r_run_ident;
        n_run_left  = r_run_left;
        n_count     = r_count;
        if (w_insert) begin
            n_count = r_count + CNT_W'(1);
        end
        if (w_take && w_tick) begin
            if (w_dispatch) begin
                n_run_flag  = 1'b1;
                n_run_ident = w_head.ident;
                n_run_left  = w_head.length - ljf_pkg::LEN_W'(1);
                n_count     = r_count - CNT_W'(1);
            end else if (w_finish) begin
                n_run_flag = 1'b0;
            end else if (r_run_flag) begin
                n_run_left = r_run_left - ljf_pkg::LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_tick      <= '0;
            r_run_flag  <= 1'b0;
            r_run_ident <= '0;
            r_run_left  <= '0;
            r_count     <= '0;
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_take && w_tick) begin
                r_tick <= r_tick + ljf_pkg::TICK_W'(1);
            end
            r_run_flag  <= n_run_flag;
            r_run_ident <= n_run_ident;
            r_run_left  <= n_run_left;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_accepted       <= w_insert;
            r_dispatch_valid <= w_dispatch;
            r_dispatch_ident <= w_dispatch ? w_head.ident : '0;
            r_dispatch_wait  <= w_dispatch ? (r_tick - w_head.arrival) : '0;
            r_finish_valid   <= w_finish;
            r_finish_ident   <= w_finish ? r_run_ident : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_accepted;
    assign o_dispatch_valid = r_dispatch_valid;
    assign o_dispatch_ident = r_dispatch_ident;
    assign o_dispatch_wait  = r_dispatch_wait;
    assign o_finish_valid   = r_finish_valid;
    assign o_finish_ident   = r_finish_ident;
    assign o_server_busy    = r_run_flag;
    assign o_waiting_count  = ljf_pkg::COUNT_OUT_W'(r_count);

endmodule

/* rtl/ljf_cell.sv */
// One cell of the sorted waiting queue.
// Holds one job entry and exchanges it with its neighbors on insert and pop.
// Depends on ljf_pkg.
`timescale 1ns / 1ps

module ljf_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ljf_pkg::t_cell_cmd i_cmd,
    input  ljf_pkg::t_entry    i_new,
    input  ljf_pkg::t_entry    i_prev,
    input  logic               i_prev_keep,
    input  ljf_pkg::t_entry    i_next,
    output ljf_pkg::t_entry    o_entry,
    output logic               o_keep
);

    ljf_pkg::t_entry r_entry;
    ljf_pkg::t_entry n_entry;

    // A cell keeps its place when its job is strictly longer than the new one.
    assign o_keep  = r_entry.valid && (r_entry.length > i_new.length);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.pop) begin
            n_entry = i_next;
        end else if (i_cmd.insert) begin
            if (!i_prev_keep) begin
                n_entry = i_prev;
            end else if (!o_keep) begin
                n_entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.ident   <= n_entry.ident;
        r_entry.length  <= n_entry.length;
        r_entry.arrival <= n_entry.arrival;
    end

endmodule

/* rtl/ljf_chain.sv */
// Row of queue cells kept sorted by length, longest and newest at the head.
// Instantiates ljf_cell; depends on ljf_pkg.
`timescale 1ns / 1ps

module ljf_chain #(
    parameter int DEPTH = ljf_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ljf_pkg::t_cell_cmd i_cmd,
    input  ljf_pkg::t_entry    i_new,
    output ljf_pkg::t_entry    o_head,
    output logic               o_full
);

    ljf_pkg::t_entry w_entry [DEPTH];
    logic            w_keep  [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ljf_pkg::t_entry w_prev;
        ljf_pkg::t_entry w_next;
        logic            w_prev_keep;

        if (g == 0) begin : g_first
            assign w_prev      = '0;
            assign w_prev_keep = 1'b1;
        end else begin : g_mid
            assign w_prev      = w_entry[g-1];
            assign w_prev_keep = w_keep[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_entry[g+1];
        end

        ljf_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (i_cmd),
            .i_new       (i_new),
            .i_prev      (w_prev),
            .i_prev_keep (w_prev_keep),
            .i_next      (w_next),
            .o_entry     (w_entry[g]),
            .o_keep      (w_keep[g])
        );
    end

    assign o_head = w_entry[0];
    assign o_full = w_entry[DEPTH-1].valid;

endmodule

/* tb/ljf_checker.sv */
// Scoreboard for the longest-job-first scheduler: watches both channels,
// predicts each result from its own model of queue and server, and compares.
// Depends on ljf_pkg for field widths, queue depth and operation codes.
`timescale 1ns / 1ps

module ljf_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic                            i_operation,
    input  logic [ljf_pkg::IDENT_W-1:0]     i_job_ident,
    input  logic [ljf_pkg::LEN_W-1:0]       i_job_length,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic                            i_accepted,
    input  logic                            i_dispatch_valid,
    input  logic [ljf_pkg::IDENT_W-1:0]     i_dispatch_ident,
    input  logic [ljf_pkg::TICK_W-1:0]      i_dispatch_wait,
    input  logic                            i_finish_valid,
    input  logic [ljf_pkg::IDENT_W-1:0]     i_finish_ident,
    input  logic                            i_server_busy,
    input  logic [ljf_pkg::COUNT_OUT_W-1:0] i_waiting_count,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int DEPTH = ljf_pkg::QUEUE_DEPTH;

    typedef struct packed {
        logic                            accepted;
        logic                            dispatch_valid;
        logic [ljf_pkg::IDENT_W-1:0]     dispatch_ident;
        logic [ljf_pkg::TICK_W-1:0]      dispatch_wait;
        logic                            finish_valid;
        logic [ljf_pkg::IDENT_W-1:0]     finish_ident;
        logic                            server_busy;
        logic [ljf_pkg::COUNT_OUT_W-1:0] waiting_count;
    } t_sched_result;

    logic [ljf_pkg::TICK_W-1:0]  tick_count;
    logic                        running;
    logic [ljf_pkg::IDENT_W-1:0] run_ident;
    logic [ljf_pkg::LEN_W-1:0]   run_left;
    logic [ljf_pkg::IDENT_W-1:0] wait_ident [DEPTH];
    logic [ljf_pkg::LEN_W-1:0]   wait_length [DEPTH];
    logic [ljf_pkg::TICK_W-1:0]  wait_arrival [DEPTH];
    int                          queued;
    t_sched_result               expected_results [$];

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    // Advances the scheduler model by one transaction and returns its result.
    task automatic schedule_step(input logic op, input logic [ljf_pkg::IDENT_W-1:0] ident,
                                 input logic [ljf_pkg::LEN_W-1:0] len,
                                 output t_sched_result res);
        int best;
        int k;
        res = '0;
        if (op == ljf_pkg::OP_ARRIVE) begin
            if (queued < DEPTH && len != '0) begin
                wait_ident[queued]   = ident;
                wait_length[queued]  = len;
                wait_arrival[queued] = tick_count;
                queued++;
                res.accepted = 1'b1;
            end
        end else begin
            if (running && run_left == '0) begin
                running          = 1'b0;
                res.finish_valid = 1'b1;
                res.finish_ident = run_ident;
            end
            if (!running && queued > 0) begin
                best = 0;
                for (k = 1; k < queued; k++) begin
                    if (wait_length[k] >= wait_length[best]) begin
                        best = k;
                    end
                end
                running            = 1'b1;
                run_ident          = wait_ident[best];
                run_left           = wait_length[best];
                res.dispatch_valid = 1'b1;
                res.dispatch_ident = wait_ident[best];
                res.dispatch_wait  = tick_count - wait_arrival[best];
                for (k = best; k + 1 < queued; k++) begin
                    wait_ident[k]   = wait_ident[k+1];
                    wait_length[k]  = wait_length[k+1];
                    wait_arrival[k] = wait_arrival[k+1];
                end
                queued--;
            end
            if (running && run_left != '0) begin
                run_left = run_left - ljf_pkg::LEN_W'(1);
            end
            tick_count = tick_count + ljf_pkg::TICK_W'(1);
        end
        res.server_busy   = running;
        res.waiting_count = ljf_pkg::COUNT_OUT_W'(queued);
    endtask

    always @(posedge i_clk) begin
        t_sched_result want;
        t_sched_result got;
        if (!i_rst_n) begin
            tick_count = '0;
            running    = 1'b0;
            run_ident  = '0;
            run_left   = '0;
            queued     = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transaction with no expectation waiting");
                end else begin
                    want = expected_results.pop_front();
                    got  = {i_accepted, i_dispatch_valid, i_dispatch_ident, i_dispatch_wait,
                            i_finish_valid, i_finish_ident, i_server_busy, i_waiting_count};
                    check_field("accepted", 32'(got.accepted), 32'(want.accepted));
                    check_field("dispatch_valid", 32'(got.dispatch_valid),
                                32'(want.dispatch_valid));
                    check_field("dispatch_ident", 32'(got.dispatch_ident),
                                32'(want.dispatch_ident));
                    check_field("dispatch_wait", got.dispatch_wait, want.dispatch_wait);
                    check_field("finish_valid", 32'(got.finish_valid), 32'(want.finish_valid));
                    check_field("finish_ident", 32'(got.finish_ident), 32'(want.finish_ident));
                    check_field("server_busy", 32'(got.server_busy), 32'(want.server_busy));
                    check_field("waiting_count", 32'(got.waiting_count),
                                32'(want.waiting_count));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                schedule_step(i_operation, i_job_ident, i_job_length, want);
                expected_results.push_back(want);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

/* tb/tb.sv */
// Top of the scheduler testbench: clock, reset, stimulus, receiver stalls,
// watchdog and verdict. Instantiates longest_job_first_scheduler beside
// ljf_checker, which does all prediction and comparison; depends on ljf_pkg.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 64;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic                            i_operation;
    logic [ljf_pkg::IDENT_W-1:0]     i_job_ident;
    logic [ljf_pkg::LEN_W-1:0]       i_job_length;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic                            o_accepted;
    logic                            o_dispatch_valid;
    logic [ljf_pkg::IDENT_W-1:0]     o_dispatch_ident;
    logic [ljf_pkg::TICK_W-1:0]      o_dispatch_wait;
    logic                            o_finish_valid;
    logic [ljf_pkg::IDENT_W-1:0]     o_finish_ident;
    logic                            o_server_busy;
    logic [ljf_pkg::COUNT_OUT_W-1:0] o_waiting_count;

    int   fail_count;
    int   pending;
    int   items_sent;
    int   quiet_cycles;
    int   hold_left;
    logic idle_on;
    logic hold_req;

    longest_job_first_scheduler DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_job_ident      (i_job_ident),
        .i_job_length     (i_job_length),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_accepted       (o_accepted),
        .o_dispatch_valid (o_dispatch_valid),
        .o_dispatch_ident (o_dispatch_ident),
        .o_dispatch_wait  (o_dispatch_wait),
        .o_finish_valid   (o_finish_valid),
        .o_finish_ident   (o_finish_ident),
        .o_server_busy    (o_server_busy),
        .o_waiting_count  (o_waiting_count)
    );

    ljf_checker u_sched_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_job_ident      (i_job_ident),
        .i_job_length     (i_job_length),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_accepted       (o_accepted),
        .i_dispatch_valid (o_dispatch_valid),
        .i_dispatch_ident (o_dispatch_ident),
        .i_dispatch_wait  (o_dispatch_wait),
        .i_finish_valid   (o_finish_valid),
        .i_finish_ident   (o_finish_ident),
        .i_server_busy    (o_server_busy),
        .i_waiting_count  (o_waiting_count),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // The receiver stalls at random, or for a long stretch when asked to.
    initial begin
        logic hold_taken;
        i_out_stall = 1'b0;
        hold_left   = 0;
        hold_taken  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                i_out_stall = idle_on && ($urandom_range(0, 99) < 7);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Offers one transaction starting at a falling edge and returns at the
    // falling edge after it was taken, leaving valid high for the next one.
    task automatic send_item(input logic op, input logic [ljf_pkg::IDENT_W-1:0] ident,
                             input logic [ljf_pkg::LEN_W-1:0] len);
        while (idle_on && $urandom_range(0, 99) < 7) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_operation  = op;
        i_job_ident  = ident;
        i_job_length = len;
        i_in_valid   = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) begin
                break;
            end
            @(negedge i_clk);
        end
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(ljf_pkg::OP_TICK, ljf_pkg::IDENT_W'($urandom_range(0, 255)),
                  ljf_pkg::LEN_W'($urandom_range(0, 65535)));
    endtask

    task automatic send_arrival(input logic [ljf_pkg::LEN_W-1:0] len);
        send_item(ljf_pkg::OP_ARRIVE, ljf_pkg::IDENT_W'($urandom_range(0, 255)), len);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int  i;
        int  pick;
        logic hold_done;
        logic pause_done;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_operation  = ljf_pkg::OP_ARRIVE;
        i_job_ident  = '0;
        i_job_length = '0;
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        items_sent   = 0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero length is dropped, a tick with nothing queued does nothing, and
        // two equal lengths go out most recent first.
        send_item(ljf_pkg::OP_ARRIVE, 8'h11, 16'h0000);
        send_tick();
        send_item(ljf_pkg::OP_ARRIVE, 8'hFF, 16'h0001);
        send_item(ljf_pkg::OP_ARRIVE, 8'h00, 16'h0001);
        send_tick();
        send_tick();
        // Fill the queue, then one arrival more is refused.
        for (i = 0; i < ljf_pkg::QUEUE_DEPTH; i++) begin
            send_item(ljf_pkg::OP_ARRIVE, ljf_pkg::IDENT_W'(8'h20 + i),
                      ljf_pkg::LEN_W'($urandom_range(1, 3)));
        end
        send_item(ljf_pkg::OP_ARRIVE, 8'h7F, 16'hFFFF);
        send_tick();

        while (items_sent < 330) begin
            if (!hold_done && items_sent >= 120) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            idle_on = !(items_sent >= 200 && items_sent < 280);
            if (!pause_done && items_sent >= 250) begin
                pause_done = 1'b1;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                // A burst that is sure to overflow the queue; the last four
                // carry random full-width lengths and are all refused.
                for (i = 0; i < 16; i++) begin
                    send_arrival(ljf_pkg::LEN_W'($urandom_range(1, 4)));
                end
                for (i = 0; i < 4; i++) begin
                    send_arrival(ljf_pkg::LEN_W'($urandom_range(0, 65535)));
                end
            end else if (pick < 48) begin
                send_arrival(($urandom_range(0, 99) < 5) ? 16'h0000 :
                             ljf_pkg::LEN_W'($urandom_range(1, 5)));
            end else begin
                send_tick();
            end
        end

        // Enough ticks to empty the queue and finish the running job.
        for (i = 0; i < 100; i++) begin
            send_tick();
        end
        // Large lengths compared at the top bits, with a tie at the maximum.
        send_item(ljf_pkg::OP_ARRIVE, 8'hA1, 16'hFFFF);
        send_item(ljf_pkg::OP_ARRIVE, 8'h5C, 16'h8000);
        send_item(ljf_pkg::OP_ARRIVE, 8'hA2, 16'hFFFF);
        send_item(ljf_pkg::OP_ARRIVE, 8'h3E, 16'h7FFF);
        send_tick();
        send_tick();
        send_tick();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* longest_job_first_scheduler.f */
rtl/ljf_pkg.sv
rtl/ljf_cell.sv
rtl/ljf_chain.sv
rtl/longest_job_first_scheduler.sv
tb/ljf_checker.sv
tb/tb.sv
